@@ hw/rtl/iou_pkg.sv @@
// Shared types and constants for the interval IoU cluster matcher.
package iou_pkg;

  localparam int unsigned TimeW    = 18;
  localparam int unsigned ScoreW   = 18;
  localparam int unsigned ThrW     = 17;
  localparam int unsigned TallyW   = 8;
  localparam int unsigned SelW     = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned NumClus  = 3;

  // Fraction bits of the pair score; the score and threshold widths are set on their own above
  localparam int unsigned FracBits = 16;

  localparam logic [CfgIdxW-1:0] CfgIdxThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMinHits   = 2'd1;

  localparam logic [ThrW-1:0]   ThresholdReset = '0;
  localparam logic [TallyW-1:0] MinHitsReset   = 8'd10;
  localparam logic [TallyW-1:0] TallyMax       = 8'd255;

  // Cluster pairs in scoring order
  localparam logic [1:0] PairAB = 2'd0;
  localparam logic [1:0] PairAC = 2'd1;
  localparam logic [1:0] PairBC = 2'd2;

  localparam logic [1:0] NclusTwo   = 2'd2;
  localparam logic [1:0] NclusThree = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StDiv,
    StAcc,
    StDone
  } iou_state_e;

  typedef struct packed {
    logic track;      // take the hit into the trackers
    logic close;      // group ends with this hit
    logic load;       // set up the divider for the current pair
    logic step;       // one quotient bit
    logic reject;     // mark the group as rejected
    logic accum;      // add the pair score to the sum
    logic next_pair;  // advance to the next pair
    logic emit;       // present the result and clear the trackers
  } iou_cmd_t;

  typedef struct packed {
    logic pair_fail;
    logic pair_zero;
    logic div_done;
    logic thr_fail;
    logic more_pairs;
  } iou_status_t;

endpackage

@@ hw/rtl/iou_ctrl.sv @@
// Group-end sequencer for the interval IoU cluster matcher.
module iou_ctrl import iou_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        last_hit_i,
  input  iou_status_t status_i,
  output iou_cmd_t    cmd_o,
  output logic        busy_o
);

  iou_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i && last_hit_i) state_d = StEval;
      end
      StEval: begin
        if (status_i.pair_fail)      state_d = StDone;
        else if (status_i.pair_zero) state_d = StAcc;
        else                         state_d = StDiv;
      end
      StDiv: begin
        if (status_i.div_done) state_d = StAcc;
      end
      StAcc: begin
        if (status_i.thr_fail)        state_d = StDone;
        else if (status_i.more_pairs) state_d = StEval;
        else                          state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      StIdle: begin
        busy_o      = 1'b0;
        cmd_o.track = start_i;
        cmd_o.close = start_i && last_hit_i;
      end
      StEval: begin
        cmd_o.load   = 1'b1;
        cmd_o.reject = status_i.pair_fail;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
      end
      StAcc: begin
        cmd_o.reject    = status_i.thr_fail;
        cmd_o.accum     = !status_i.thr_fail;
        cmd_o.next_pair = !status_i.thr_fail && status_i.more_pairs;
      end
      StDone: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/iou_datapath.sv @@
// Span trackers, pair checks, serial divider and score sum of the IoU matcher.
module iou_datapath import iou_pkg::*; #(
  parameter int unsigned MAX_TICKS = 9600
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iou_cmd_t            cmd_i,
  output iou_status_t         status_o,
  input  logic [SelW-1:0]     cluster_sel_i,
  input  logic [TimeW-1:0]    hit_time_i,
  input  logic [1:0]          group_clusters_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                done_o,
  output logic                matched_o,
  output logic [ScoreW-1:0]   score_o
);

  localparam int unsigned QW   = FracBits + 1;
  localparam int unsigned CntW = $clog2(FracBits + 1);
  localparam int unsigned CmpW = (QW > ThrW) ? QW : ThrW;
  localparam logic [TimeW-1:0] TimeCap = TimeW'(MAX_TICKS * 16);

  logic [ThrW-1:0]   thr_q;
  logic [TallyW-1:0] min_hits_q;

  logic [TimeW-1:0]  lo_q    [NumClus];
  logic [TimeW-1:0]  hi_q    [NumClus];
  logic [TallyW-1:0] tally_q [NumClus];

  logic [1:0]        nclus_q;
  logic [1:0]        pair_q;
  logic              ok_q;
  logic [ScoreW-1:0] total_q;

  logic [TimeW:0]    rem_q, rem_d;
  logic [TimeW-1:0]  div_q;
  logic [QW-1:0]     quo_q, quo_d;
  logic [CntW-1:0]   cnt_q;

  logic              done_q, matched_q;
  logic [ScoreW-1:0] score_q;

  logic [TimeW-1:0]  t_sat;
  logic [TimeW-1:0]  lo_a, hi_a, lo_b, hi_b, c_lo, c_hi, u_lo, u_hi, overlap, joint;
  logic [TallyW-1:0] tal_a, tal_b;
  logic [TimeW:0]    trial;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThresholdReset;
      min_hits_q <= MinHitsReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxThreshold) thr_q      <= cfg_data_i[ThrW-1:0];
      if (cfg_index_i == CfgIdxMinHits)   min_hits_q <= cfg_data_i[TallyW-1:0];
    end
  end

  assign t_sat = (hit_time_i > TimeCap) ? TimeCap : hit_time_i;

  // Trackers: one min/max/count per cluster
  for (genvar i = 0; i < NumClus; i++) begin : g_trk
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lo_q[i]    <= TimeCap;
        hi_q[i]    <= '0;
        tally_q[i] <= '0;
      end else if (cmd_i.emit) begin
        lo_q[i]    <= TimeCap;
        hi_q[i]    <= '0;
        tally_q[i] <= '0;
      end else if (cmd_i.track && cluster_sel_i == SelW'(i)) begin
        if (t_sat < lo_q[i]) lo_q[i] <= t_sat;
        if (t_sat > hi_q[i]) hi_q[i] <= t_sat;
        if (tally_q[i] != TallyMax) tally_q[i] <= tally_q[i] + 8'd1;
      end
    end
  end

  // Pick the two clusters of the current pair
  always_comb begin
    case (pair_q)
      PairAC: begin
        lo_a = lo_q[0]; hi_a = hi_q[0]; tal_a = tally_q[0];
        lo_b = lo_q[2]; hi_b = hi_q[2]; tal_b = tally_q[2];
      end
      PairBC: begin
        lo_a = lo_q[1]; hi_a = hi_q[1]; tal_a = tally_q[1];
        lo_b = lo_q[2]; hi_b = hi_q[2]; tal_b = tally_q[2];
      end
      default: begin
        lo_a = lo_q[0]; hi_a = hi_q[0]; tal_a = tally_q[0];
        lo_b = lo_q[1]; hi_b = hi_q[1]; tal_b = tally_q[1];
      end
    endcase
  end

  assign c_lo    = (lo_a > lo_b) ? lo_a : lo_b;
  assign c_hi    = (hi_a < hi_b) ? hi_a : hi_b;
  assign u_lo    = (lo_a < lo_b) ? lo_a : lo_b;
  assign u_hi    = (hi_a > hi_b) ? hi_a : hi_b;
  assign overlap = c_hi - c_lo;
  assign joint   = (u_hi >= u_lo) ? (u_hi - u_lo) : '0;

  assign status_o.pair_fail = (nclus_q < NclusTwo) || (tal_a < min_hits_q) ||
                              (tal_b < min_hits_q) || (hi_b < lo_a) ||
                              (lo_b > hi_a) || (c_hi < c_lo);
  assign status_o.pair_zero  = (joint == '0);
  assign status_o.div_done   = (cnt_q == CntW'(FracBits));
  assign status_o.thr_fail   = CmpW'(quo_q) < CmpW'(thr_q);
  assign status_o.more_pairs = (nclus_q == NclusThree) && (pair_q != PairBC);

  // Restoring divider: first bit weighs one, then a shift each step
  assign trial = (cnt_q == '0) ? rem_q : {rem_q[TimeW-1:0], 1'b0};

  always_comb begin
    if (trial >= {1'b0, div_q}) begin
      rem_d = trial - {1'b0, div_q};
      quo_d = {quo_q[QW-2:0], 1'b1};
    end else begin
      rem_d = trial;
      quo_d = {quo_q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= {1'b0, overlap};
      div_q <= joint;
      quo_q <= status_o.pair_zero ? (QW'(1) << FracBits) : '0;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Group bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nclus_q <= '0;
      pair_q  <= PairAB;
      ok_q    <= 1'b0;
      total_q <= '0;
    end else begin
      if (cmd_i.close) begin
        nclus_q <= group_clusters_i;
        pair_q  <= PairAB;
        ok_q    <= 1'b1;
        total_q <= '0;
      end
      if (cmd_i.reject)    ok_q    <= 1'b0;
      if (cmd_i.accum)     total_q <= total_q + ScoreW'(quo_q);
      if (cmd_i.next_pair) pair_q  <= pair_q + 2'd1;
    end
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      matched_q <= ok_q;
      score_q   <= ok_q ? total_q : '0;
    end
  end

  assign done_o    = done_q;
  assign matched_o = matched_q;
  assign score_o   = score_q;

endmodule

@@ hw/rtl/interval_iou_cluster_match_core.sv @@
// Top level of the interval IoU cluster matcher: sequencer plus datapath.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   hit in   | start_i, busy_o           | cluster_sel_i, hit_time_i, group_clusters_i,
//            |                           | last_hit_i
//   result   | done_o (one-cycle strobe) | matched_o, score_o
//   config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A hit without last_hit leaves busy_o low; hits may arrive back to back.
// A last hit holds busy_o while each pair is checked, run through the
// bit-serial divider and added to the score, and then while the result
// is emitted; two clusters give one pair, three clusters give three pairs.
// A failed pair ends early and a zero-length span skips the divider.
// The result strobe follows in the cycle busy_o drops. The receiver cannot
// stall; no reset sweep.
module interval_iou_cluster_match_core import iou_pkg::*; #(
  parameter int unsigned MAX_TICKS = 9600
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [SelW-1:0]     cluster_sel_i,
  input  logic [TimeW-1:0]    hit_time_i,
  input  logic [1:0]          group_clusters_i,
  input  logic                last_hit_i,
  output logic                done_o,
  output logic                matched_o,
  output logic [ScoreW-1:0]   score_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  iou_cmd_t    cmd;
  iou_status_t status;

  assign cfg_ready_o = 1'b1;

  iou_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .last_hit_i (last_hit_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  iou_datapath #(
    .MAX_TICKS (MAX_TICKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cluster_sel_i    (cluster_sel_i),
    .hit_time_i       (hit_time_i),
    .group_clusters_i (group_clusters_i),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .matched_o        (matched_o),
    .score_o          (score_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_hit_i) |=> busy_o)
    else $error("group end did not start scoring");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !matched_o) |-> (score_o == '0))
    else $error("rejected group carries a score");

  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

@@ tb/iou_match_check_pkg.sv @@
`timescale 1ns / 100ps
// Group verdict tracker for the interval IoU cluster matcher test.
package iou_match_check_pkg;
  import iou_pkg::*;

  localparam int unsigned TbMaxTicks = 9600;
  localparam int unsigned TbFracBits = 16;

  localparam logic [TimeW-1:0]   TimeCap      = TimeW'(TbMaxTicks << 4);
  localparam int unsigned        TimeFieldMax = (1 << TimeW) - 1;
  localparam logic [SelW-1:0]    SelNone      = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;

  typedef struct packed {
    logic              matched;
    logic [ScoreW-1:0] score;
  } verdict_t;

  class iou_group_scorer;
    logic [ThrW-1:0]   threshold;
    logic [TallyW-1:0] min_hits;
    logic [TimeW-1:0]  first_time [NumClus];
    logic [TimeW-1:0]  last_time [NumClus];
    logic [TallyW-1:0] tally [NumClus];
    verdict_t          expected_verdicts [$];
    int unsigned       hits_seen, groups_matched, groups_rejected, mismatches, reg_writes;

    function new();
      threshold = ThresholdReset;
      min_hits  = MinHitsReset;
      clear_spans();
    endfunction

    function void clear_spans();
      for (int k = 0; k < NumClus; k++) begin
        first_time[k] = TimeCap;
        last_time[k]  = '0;
        tally[k]      = '0;
      end
    endfunction

    function void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      reg_writes++;
      case (idx)
        CfgIdxThreshold: threshold = data[ThrW-1:0];
        CfgIdxMinHits:   min_hits  = data[TallyW-1:0];
        default: ;
      endcase
    endfunction

    // Overlap over joint span of clusters a and b; 0 when the pair fails
    function bit pair_iou(int a, int b, output logic [ScoreW-1:0] s);
      logic [TimeW-1:0] c_lo, c_hi, u_lo, u_hi, joint;
      logic [63:0]      ratio;
      s = '0;
      if (tally[a] < min_hits || tally[b] < min_hits) return 0;
      if (last_time[b] < first_time[a] || first_time[b] > last_time[a]) return 0;
      c_lo = (first_time[a] > first_time[b]) ? first_time[a] : first_time[b];
      c_hi = (last_time[a] < last_time[b]) ? last_time[a] : last_time[b];
      // an empty cluster can leave the overlap inverted
      if (c_hi < c_lo) return 0;
      u_lo  = (first_time[a] < first_time[b]) ? first_time[a] : first_time[b];
      u_hi  = (last_time[a] > last_time[b]) ? last_time[a] : last_time[b];
      joint = (u_hi >= u_lo) ? u_hi - u_lo : '0;
      if (joint == '0) ratio = 64'd1 << TbFracBits;
      else ratio = (64'(c_hi - c_lo) << TbFracBits) / 64'(joint);
      if (ratio < 64'(threshold)) return 0;
      s = ScoreW'(ratio);
      return 1;
    endfunction

    function void note_hit(logic [SelW-1:0] sel, logic [TimeW-1:0] t_in, logic [1:0] nclus,
                           logic last);
      logic [TimeW-1:0]  t;
      logic [ScoreW-1:0] s, total;
      bit                ok;
      verdict_t          v;
      hits_seen++;
      t = (t_in > TimeCap) ? TimeCap : t_in;
      if (sel != SelNone) begin
        if (t < first_time[sel]) first_time[sel] = t;
        if (t > last_time[sel]) last_time[sel] = t;
        if (tally[sel] != TallyMax) tally[sel]++;
      end
      if (!last) return;
      total = '0;
      ok = (nclus >= NclusTwo);
      if (ok) begin
        ok = pair_iou(0, 1, s);
        total = s;
      end
      if (ok && nclus == NclusThree) begin
        ok = pair_iou(0, 2, s);
        total += s;
        if (ok) begin
          ok = pair_iou(1, 2, s);
          total += s;
        end
      end
      v.matched = ok;
      v.score   = ok ? total : '0;
      expected_verdicts.push_back(v);
      if (ok) groups_matched++;
      else groups_rejected++;
      clear_spans();
    endfunction

    function void check_result(logic matched, logic [ScoreW-1:0] score);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        $error("result with no group outstanding: matched %0d score %0d", matched, score);
        mismatches++;
        return;
      end
      v = expected_verdicts.pop_front();
      if (matched !== v.matched) begin
        $error("matched: expected %0d, actual %0d", v.matched, matched);
        mismatches++;
      end
      if (score !== v.score) begin
        $error("score: expected %0d, actual %0d", v.score, score);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/interval_iou_cluster_match_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking test of the interval IoU cluster matcher with directed and random groups.
module interval_iou_cluster_match_core_test;
  import iou_pkg::*;
  import iou_match_check_pkg::*;

  localparam int unsigned ClkPeriod    = 4;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomHits   = 650;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned NumSettings  = 6;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [SelW-1:0]     cluster_sel    = '0;
  logic [TimeW-1:0]    hit_time       = '0;
  logic [1:0]          group_clusters = '0;
  logic                last_hit       = 1'b0;
  logic                cfg_valid      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index      = '0;
  logic [CfgDataW-1:0] cfg_data       = '0;
  logic                busy, done, matched, cfg_ready;
  logic [ScoreW-1:0]   score;

  iou_group_scorer scorer;
  int unsigned     cycles = 0;
  int unsigned     idle_pct = 0;
  int unsigned     random_sent = 0;

  interval_iou_cluster_match_core #(
    .MAX_TICKS(TbMaxTicks)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .cluster_sel_i   (cluster_sel),
    .hit_time_i      (hit_time),
    .group_clusters_i(group_clusters),
    .last_hit_i      (last_hit),
    .done_o          (done),
    .matched_o       (matched),
    .score_o         (score),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && done) scorer.check_result(matched, score);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold start high across back-to-back hits; drop it only for an idle gap
  task automatic send_hit(input logic [SelW-1:0] sel, input logic [TimeW-1:0] t,
                          input logic [1:0] nclus, input logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    cluster_sel    <= sel;
    hit_time       <= t;
    group_clusters <= nclus;
    last_hit       <= last;
    do @(posedge clk); while (busy);
    scorer.note_hit(sel, t, nclus, last);
  endtask

  task automatic wait_for_verdicts(input int unsigned tail);
    start <= 1'b0;
    while (scorer.expected_verdicts.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Write threshold then minimum hits; spare indexes afterwards must change nothing
  task automatic program_regs(input logic [ThrW-1:0] thr, input logic [TallyW-1:0] mh,
                              input bit spare);
    logic [CfgIdxW-1:0]  idx [4];
    logic [CfgDataW-1:0] val [4];
    int unsigned         n;
    idx[0] = CfgIdxThreshold;
    val[0] = CfgDataW'(thr);
    idx[1] = CfgIdxMinHits;
    val[1] = {9'($urandom_range(0, 511)), mh};
    idx[2] = CfgIdxSpare2;
    val[2] = CfgDataW'($urandom);
    idx[3] = CfgIdxSpare3;
    val[3] = CfgDataW'($urandom);
    n = spare ? 4 : 2;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      scorer.apply_register(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Interleave the given hit counts per cluster at random; the final hit closes the group
  task automatic run_group(input int unsigned n0, n1, n2, n3, input logic [1:0] nclus,
                           input int unsigned base, shift, spread);
    int unsigned left [4];
    int unsigned origin [4];
    int unsigned total, pick, t, k;
    logic [1:0]  nc;
    left  = '{n0, n1, n2, n3};
    total = n0 + n1 + n2 + n3;
    for (int c = 0; c < 4; c++) origin[c] = base + $urandom_range(0, shift);
    while (total != 0) begin
      pick = $urandom_range(0, total - 1);
      k = 0;
      while (pick >= left[k]) begin
        pick -= left[k];
        k++;
      end
      left[k]--;
      total--;
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TimeFieldMax)
                                      : origin[k] + $urandom_range(0, spread);
      if (t > TimeFieldMax) t = TimeFieldMax;
      if (k != SelNone) random_sent++;
      if (random_sent < RandomHits / 3) idle_pct = 20;
      else if (random_sent < 2 * RandomHits / 3) idle_pct = 69;
      else idle_pct = 0;
      // the cluster count only matters on the closing hit
      nc = (total == 0) ? nclus : 2'($urandom_range(0, 3));
      send_hit(SelW'(k), TimeW'(t), nc, total == 0);
    end
  endtask

  initial begin
    logic [ThrW-1:0]   set_thr [NumSettings];
    logic [TallyW-1:0] set_min [NumSettings];
    int unsigned       set_hits [NumSettings];
    int unsigned       cnt [3];
    int unsigned       extra, goal, r;
    logic [1:0]        nclus;

    scorer = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset minimum of ten hits rejects single-hit clusters
    send_hit(2'd0, 18'd100, 2'd0, 1'b0);
    send_hit(2'd1, 18'd100, NclusTwo, 1'b1);
    wait_for_verdicts(8);
    program_regs('0, 8'd1, 1'b1);
    // Both times saturate to the cap: zero-length joint span scores exactly one
    send_hit(2'd0, TimeW'(TimeFieldMax), 2'd0, 1'b0);
    send_hit(2'd1, 18'd200000, NclusTwo, 1'b1);
    // Three clusters, closed by a hit outside every cluster
    send_hit(2'd0, 18'd0, 2'd1, 1'b0);
    send_hit(2'd0, 18'd160, 2'd0, 1'b0);
    send_hit(2'd1, 18'd80, 2'd3, 1'b0);
    send_hit(2'd1, 18'd240, 2'd0, 1'b0);
    send_hit(2'd2, 18'd40, 2'd0, 1'b0);
    send_hit(2'd2, 18'd200, 2'd0, 1'b0);
    send_hit(SelNone, 18'd5, NclusThree, 1'b1);
    // Cluster counts below two
    send_hit(2'd0, 18'd10, 2'd0, 1'b0);
    send_hit(2'd1, 18'd10, 2'd1, 1'b1);
    send_hit(2'd0, 18'd10, 2'd0, 1'b1);
    // Third cluster hits ignored in a two-cluster group
    send_hit(2'd0, 18'd0, 2'd0, 1'b0);
    send_hit(2'd0, 18'd100, 2'd0, 1'b0);
    send_hit(2'd2, 18'd30000, 2'd0, 1'b0);
    send_hit(2'd1, 18'd50, NclusTwo, 1'b1);
    wait_for_verdicts(8);
    program_regs('0, 8'd0, 1'b0);
    // Empty cluster passes the count check but leaves an inverted overlap
    send_hit(2'd0, 18'd0, 2'd0, 1'b0);
    send_hit(2'd0, TimeCap, NclusTwo, 1'b1);
    send_hit(SelNone, 18'd7, NclusTwo, 1'b1);
    wait_for_verdicts(8);
    // Threshold above one rejects even a perfect pair, exactly one just passes
    program_regs(17'h1FFFF, 8'd1, 1'b0);
    send_hit(2'd0, 18'd5, 2'd0, 1'b0);
    send_hit(2'd1, 18'd5, NclusTwo, 1'b1);
    wait_for_verdicts(8);
    program_regs(17'h10000, 8'd1, 1'b0);
    send_hit(2'd0, 18'd5, 2'd0, 1'b0);
    send_hit(2'd1, 18'd5, NclusTwo, 1'b1);

    set_thr  = '{17'h00000, 17'h0C000, ThrW'($urandom_range(0, 65536)), 17'h10000,
                 17'h1FFFF, 17'h00000};
    set_min  = '{8'd2, 8'd3, 8'd1, 8'd0, 8'd2, 8'd255};
    set_hits = '{100, 100, 90, 50, 30, 40};

    for (int p = 0; p < NumSettings; p++) begin
      wait_for_verdicts(8);
      program_regs(set_thr[p], set_min[p], p % 2 == 1);
      goal = random_sent + set_hits[p];
      while (random_sent < goal) begin
        r = $urandom_range(0, 9);
        nclus = (r == 0) ? 2'($urandom_range(0, 1)) : (r < 6) ? NclusTwo : NclusThree;
        for (int c = 0; c < 3; c++) begin
          if (set_min[p] > 8) cnt[c] = $urandom_range(0, 6);
          else if ($urandom_range(0, 7) == 0) cnt[c] = $urandom_range(0, set_min[p]);
          else cnt[c] = $urandom_range(set_min[p], set_min[p] + 3);
        end
        if (nclus == NclusTwo) cnt[2] = $urandom_range(0, 2);
        extra = ($urandom_range(0, 9) == 0) ? 1 : 0;
        if (cnt[0] + cnt[1] + cnt[2] + extra == 0) extra = 1;
        run_group(cnt[0], cnt[1], cnt[2], extra, nclus,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(150000, 153600)
                                              : $urandom_range(0, 150000),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20000) : 0,
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4000));
      end
    end

    // Hit tally must stick at its maximum rather than wrap
    wait_for_verdicts(8);
    program_regs('0, 8'd4, 1'b0);
    run_group(257, $urandom_range(4, 6), 0, 0, NclusTwo, 1000, 0, 3000);

    wait_for_verdicts(SettleCycles);
    $display("Checked %0d hits in %0d groups: %0d matched, %0d rejected.", scorer.hits_seen,
             scorer.groups_matched + scorer.groups_rejected, scorer.groups_matched,
             scorer.groups_rejected);
    $display("%0d register writes, thresholds 0 to all ones, minimum hits 0 to 255.",
             scorer.reg_writes);
    if (scorer.mismatches == 0 && scorer.expected_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
